// File: design/aks_pkg.sv
package aks_pkg;

  // keyframe index width; frame_count is taken modulo 2^FrameBits
  localparam int FrameBits = 16;
  // fraction bits of the normalized time (Q24.40 product)
  localparam int FracBits  = 40;

  localparam logic [1:0] ModeClamp  = 2'd0;
  localparam logic [1:0] ModeWrap   = 2'd1;
  localparam logic [1:0] ModeMirror = 2'd2;
  localparam logic [1:0] ModeUnused = 2'd3;

  typedef logic [FrameBits-1:0] frame_t;

  // per-word control carried down the pipe
  typedef struct packed {
    logic       neg;
    logic       le0;
    logic       ge_dur;
    logic [1:0] mode;
    logic [7:0] steps;
    frame_t     fc;
  } ctl_t;

  // normalized time
  typedef struct packed {
    ctl_t                ctl;
    logic [FracBits-1:0] frac;
    logic                ip_odd;
    logic                ip_ge1;
  } norm_t;

  // frames resolved, blend still raw
  typedef struct packed {
    logic        updated;
    frame_t      fr;
    frame_t      nx;
    logic        bl_zero;
    logic [7:0]  steps;
    logic [7:0]  k;
    logic [16:0] b0;
  } fpos_t;

endpackage

// File: design/aks_time_norm.sv
module aks_time_norm (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic signed [31:0]  timeline,
  input  logic [1:0]          play_mode,
  input  logic [7:0]          quantize_steps,
  input  logic [15:0]         frame_count,
  input  logic [31:0]         duration,
  input  logic [31:0]         duration_reciprocal,
  output logic                out_valid,
  output aks_pkg::norm_t      out_norm
);

  logic [31:0] raw;
  logic        neg;
  logic [aks_pkg::FrameBits+15:0] fc_ext;
  aks_pkg::ctl_t ctl_in;

  assign raw    = timeline;
  assign neg    = raw[31];
  assign fc_ext = {{aks_pkg::FrameBits{1'b0}}, frame_count};

  always_comb begin
    ctl_in.neg    = neg;
    ctl_in.le0    = neg || (raw == 32'd0);
    ctl_in.ge_dur = !neg && (raw >= duration);
    ctl_in.mode   = play_mode;
    ctl_in.steps  = quantize_steps;
    ctl_in.fc     = fc_ext[aks_pkg::FrameBits-1:0];
  end

  // stage A: magnitude and compares
  logic          a_valid;
  aks_pkg::ctl_t a_ctl;
  logic [31:0]   a_mag;
  logic [31:0]   a_rcp;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
    end
    a_ctl <= ctl_in;
    a_mag <= neg ? (~raw + 32'd1) : raw;
    a_rcp <= duration_reciprocal;
  end

  // stage B: |t| * 1/duration
  logic          b_valid;
  aks_pkg::ctl_t b_ctl;
  logic [63:0]   b_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
    b_ctl  <= a_ctl;
    b_prod <= 64'(a_mag) * 64'(a_rcp);
  end

  // stage C: fractional part, reversed for negative time
  logic [aks_pkg::FracBits-1:0] fm;
  assign fm = b_prod[aks_pkg::FracBits-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= b_valid;
    end
    out_norm.ctl    <= b_ctl;
    out_norm.frac   <= b_ctl.neg ? (~fm + 1'b1) : fm;
    out_norm.ip_odd <= b_prod[aks_pkg::FracBits];
    out_norm.ip_ge1 <= |b_prod[63:aks_pkg::FracBits];
  end

endmodule

// File: design/aks_frame_pos.sv
module aks_frame_pos (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  aks_pkg::norm_t in_norm,
  output logic           out_valid,
  output aks_pkg::fpos_t out_fpos
);

  localparam int PosBits = aks_pkg::FracBits + aks_pkg::FrameBits;

  // stage D: position = fraction * (F-1)
  logic                d_valid;
  aks_pkg::ctl_t       d_ctl;
  logic                d_ip_odd;
  logic                d_ip_ge1;
  logic [PosBits-1:0]  d_pos;
  aks_pkg::frame_t     fcm1_in;

  assign fcm1_in = in_norm.ctl.fc - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else begin
      d_valid <= in_valid;
    end
    d_ctl    <= in_norm.ctl;
    d_ip_odd <= in_norm.ip_odd;
    d_ip_ge1 <= in_norm.ip_ge1;
    d_pos    <= PosBits'(in_norm.frac) * PosBits'(fcm1_in);
  end

  // stage E: frame pair, mode handling, quantizer step index
  aks_pkg::frame_t              key;
  aks_pkg::frame_t              fcm1;
  logic [aks_pkg::FracBits-1:0] lerp;
  logic [aks_pkg::FracBits:0]   v;
  logic [aks_pkg::FracBits+8:0] kp;
  aks_pkg::fpos_t               fp;

  assign key  = d_pos[PosBits-1 -: aks_pkg::FrameBits];
  assign lerp = d_pos[aks_pkg::FracBits-1:0];
  assign fcm1 = d_ctl.fc - 1'b1;
  assign v    = d_ctl.neg ? ({1'b1, {aks_pkg::FracBits{1'b0}}} - {1'b0, lerp})
                          : {1'b0, lerp};
  assign kp   = (aks_pkg::FracBits+9)'(v) * (aks_pkg::FracBits+9)'(d_ctl.steps);

  always_comb begin
    fp.updated = 1'b1;
    fp.fr      = key;
    fp.nx      = key + 1'b1;
    fp.bl_zero = 1'b0;
    fp.steps   = d_ctl.steps;
    fp.k       = kp[aks_pkg::FracBits+7:aks_pkg::FracBits];
    fp.b0      = v[aks_pkg::FracBits:aks_pkg::FracBits-16];
    if (d_ctl.fc == '0 || d_ctl.mode == aks_pkg::ModeUnused) begin
      fp.updated = 1'b0;
      fp.fr      = '0;
      fp.nx      = '0;
      fp.bl_zero = 1'b1;
    end else if (fcm1 == '0) begin
      fp.fr      = '0;
      fp.nx      = '0;
      fp.bl_zero = 1'b1;
    end else if (d_ctl.mode == aks_pkg::ModeClamp) begin
      if (d_ctl.le0) begin
        fp.fr      = '0;
        fp.nx      = '0;
        fp.bl_zero = 1'b1;
      end else if (d_ctl.ge_dur || d_ip_ge1) begin
        fp.fr      = fcm1;
        fp.nx      = fcm1;
        fp.bl_zero = 1'b1;
      end
    end else begin
      if (d_ctl.neg) begin
        fp.fr = key + 1'b1;
        fp.nx = key;
      end
      // odd period in mirror: play frames backward
      if (d_ctl.mode == aks_pkg::ModeMirror && d_ip_odd) begin
        fp.fr = fcm1 - fp.fr;
        fp.nx = fcm1 - fp.nx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= d_valid;
    end
    out_fpos <= fp;
  end

endmodule

// File: design/aks_blend_quant.sv
module aks_blend_quant (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  aks_pkg::fpos_t in_fpos,
  output logic           done,
  output logic [15:0]    frame_index,
  output logic [15:0]    next_frame_index,
  output logic [15:0]    blend,
  output logic           updated
);

  // ceil(2^32 / s): k*2^16/s == (k * recip) >> 16 exactly for k <= 255
  logic [32:0] recip_tab [256];

  for (genvar g = 0; g < 256; g++) begin : g_recip
    localparam logic [32:0] Recip =
      33'(((64'd1 << 32) + 64'(g) - 64'd1) / ((g == 0) ? 64'd1 : 64'(g)));
    assign recip_tab[g] = Recip;
  end

  // stage F: k * recip
  logic           f_valid;
  aks_pkg::fpos_t f_fpos;
  logic [40:0]    f_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= in_valid;
    end
    f_fpos <= in_fpos;
    f_q    <= 41'(in_fpos.k) * 41'(recip_tab[in_fpos.steps]);
  end

  // stage G: select, saturate, output register
  logic [24:0] wide;
  logic [15:0] bl;
  logic [aks_pkg::FrameBits+15:0] fr_ext;
  logic [aks_pkg::FrameBits+15:0] nx_ext;

  assign wide   = (f_fpos.steps != 8'd0) ? f_q[40:16] : {8'd0, f_fpos.b0};
  assign bl     = f_fpos.bl_zero ? 16'd0 : ((|wide[24:16]) ? 16'hFFFF : wide[15:0]);
  assign fr_ext = {16'd0, f_fpos.fr};
  assign nx_ext = {16'd0, f_fpos.nx};

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= f_valid;
    end
    frame_index      <= fr_ext[15:0];
    next_frame_index <= nx_ext[15:0];
    blend            <= bl;
    updated          <= f_fpos.updated;
  end

endmodule

// File: design/animation_keyframe_sampler_top.sv
// Keyframe time sampler: timeline -> frame pair and Q0.16 blend.
// Pipeline: 7 register stages (A-G); done is registered in stage G, the last of them.
// Throughput: one word per cycle; busy stays low, the pipe never stalls.
// The multipliers (|t|*rcp, frac*(F-1), k*recip) each have their own registered stage.
// Reset (rst, synchronous): clears all pipeline valid bits; data regs keep values.
module animation_keyframe_sampler_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] timeline,
  input  logic [1:0]         play_mode,
  input  logic [7:0]         quantize_steps,
  input  logic [15:0]        frame_count,
  input  logic [31:0]        duration,
  input  logic [31:0]        duration_reciprocal,
  output logic               done,
  output logic [15:0]        frame_index,
  output logic [15:0]        next_frame_index,
  output logic [15:0]        blend,
  output logic               updated
);

  // no back-pressure anywhere: a word enters whenever start is high
  assign busy = 1'b0;

  logic           acc;
  logic           norm_valid;
  aks_pkg::norm_t norm;
  logic           fpos_valid;
  aks_pkg::fpos_t fpos;

  assign acc = start && !busy;

  // stages A-C: magnitude, |t| * 1/duration, fractional part
  aks_time_norm u_time_norm (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (acc),
    .timeline            (timeline),
    .play_mode           (play_mode),
    .quantize_steps      (quantize_steps),
    .frame_count         (frame_count),
    .duration            (duration),
    .duration_reciprocal (duration_reciprocal),
    .out_valid           (norm_valid),
    .out_norm            (norm)
  );

  // stages D-E: scale by F-1, pick the frame pair per play mode
  aks_frame_pos u_frame_pos (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (norm_valid),
    .in_norm   (norm),
    .out_valid (fpos_valid),
    .out_fpos  (fpos)
  );

  // stages F-G: quantize blend via reciprocal table, saturate, register out
  aks_blend_quant u_blend_quant (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (fpos_valid),
    .in_fpos          (fpos),
    .done             (done),
    .frame_index      (frame_index),
    .next_frame_index (next_frame_index),
    .blend            (blend),
    .updated          (updated)
  );

  // a strobe only follows an accepted word
  a_done_has_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 7))
    else $error("done without a matching start");

  // no-update words carry all-zero fields
  a_noupd_zero: assert property (@(posedge clk) disable iff (rst)
    done && !updated |-> frame_index == 16'd0 && next_frame_index == 16'd0 && blend == 16'd0)
    else $error("non-updated word has nonzero fields");

  // the unused play mode never updates
  a_unused_mode: assert property (@(posedge clk) disable iff (rst)
    done && $past(play_mode, 7) == aks_pkg::ModeUnused |-> !updated)
    else $error("unused play mode produced an update");

  // clamp at or before time zero pins to the first frame
  a_clamp_start: assert property (@(posedge clk) disable iff (rst)
    done && $past(play_mode, 7) == aks_pkg::ModeClamp && $past(timeline, 7) <= 0
      |-> frame_index == 16'd0 && next_frame_index == 16'd0 && blend == 16'd0)
    else $error("clamp before start not pinned to first frame");

endmodule

// File: dv/tb_animation_keyframe_sampler_top.sv
// Self-checking bench for the keyframe time sampler.
// A queue of stimulus words is filled up front. A clocked driver feeds the
// words to the block in bursts separated by random gaps. A clocked monitor
// checks every done strobe against the oldest predicted result.
module tb_animation_keyframe_sampler_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          NumRandom = 1250;
  localparam int          DrainWait = 12;   // pipe is 7 deep; allow margin
  localparam logic [63:0] FracOne   = 64'd1 << aks_pkg::FracBits;
  localparam logic [63:0] FracMask  = FracOne - 64'd1;
  localparam logic [63:0] FcMask    = (64'd1 << aks_pkg::FrameBits) - 64'd1;

  // one controller sample as presented to the block
  typedef struct {
    logic signed [31:0] timeline;
    logic [1:0]         mode;
    logic [7:0]         steps;
    logic [15:0]        fc;
    logic [31:0]        dur;
    logic [31:0]        rcp;
  } word_t;

  typedef struct {
    logic [15:0] frame;
    logic [15:0] next;
    logic [15:0] blend;
    logic        updated;
  } sample_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // block inputs, all known from time zero
  logic               start               = 1'b0;
  logic signed [31:0] timeline            = '0;
  logic [1:0]         play_mode           = '0;
  logic [7:0]         quantize_steps      = '0;
  logic [15:0]        frame_count         = '0;
  logic [31:0]        duration            = '0;
  logic [31:0]        duration_reciprocal = '0;

  logic        busy;
  logic        done;
  logic [15:0] frame_index;
  logic [15:0] next_frame_index;
  logic [15:0] blend;
  logic        updated;

  word_t   pending_words[$];
  sample_t expected_samples[$];
  int      errors = 0;

  animation_keyframe_sampler_top DUT (
    .clk                 (clk),
    .rst                 (rst),
    .start               (start),
    .busy                (busy),
    .timeline            (timeline),
    .play_mode           (play_mode),
    .quantize_steps      (quantize_steps),
    .frame_count         (frame_count),
    .duration            (duration),
    .duration_reciprocal (duration_reciprocal),
    .done                (done),
    .frame_index         (frame_index),
    .next_frame_index    (next_frame_index),
    .blend               (blend),
    .updated             (updated)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Turn a 40-bit fraction (up to exactly 1.0) into a Q0.16 blend.
  // Nonzero steps floor to multiples of 1/steps; 1.0 saturates to 0xFFFF.
  function automatic logic [15:0] blend_from_frac(logic [63:0] v, logic [7:0] steps);
    logic [63:0] s;
    logic [63:0] k;
    logic [63:0] b;
    s = {56'd0, steps};
    if (s != 0) begin
      k = (v * s) >> aks_pkg::FracBits;
      b = (k << 16) / s;
    end else begin
      b = v >> 24;
    end
    return (b > 64'hFFFF) ? 16'hFFFF : b[15:0];
  endfunction

  // Expected frame pair and blend for one word.
  function automatic sample_t sample_keyframes(word_t w);
    logic        neg;
    logic [63:0] mag;
    logic [63:0] prod;
    logic [63:0] ip;
    logic [63:0] fm;
    logic [63:0] fc;
    logic [63:0] frac;
    logic [63:0] pos;
    logic [63:0] key;
    logic [63:0] fr;
    logic [63:0] nx;
    logic [15:0] bl;
    logic        upd;
    sample_t     r;
    fc   = {48'd0, w.fc} & FcMask;
    neg  = w.timeline[31];
    mag  = neg ? (64'h1_0000_0000 - {32'd0, w.timeline}) : {32'd0, w.timeline};
    prod = mag * {32'd0, w.rcp};
    ip   = prod >> aks_pkg::FracBits;
    fm   = prod & FracMask;
    fr   = '0;
    nx   = '0;
    bl   = '0;
    upd  = 1'b1;
    if (fc == 0 || w.mode == aks_pkg::ModeUnused) begin
      upd = 1'b0;
    end else if (fc == 1) begin
      // single keyframe: everything zero but valid
    end else if (w.mode == aks_pkg::ModeClamp) begin
      if (neg || mag == 0) begin
        // at or before start: first frame
      end else if (mag >= {32'd0, w.dur} || ip >= 1) begin
        // past the end, or reciprocal pushes time past 1.0
        fr = fc - 1;
        nx = fc - 1;
      end else begin
        pos = fm * (fc - 1);
        key = pos >> aks_pkg::FracBits;
        fr  = key;
        nx  = key + 1;
        bl  = blend_from_frac(pos & FracMask, w.steps);
      end
    end else begin
      // wrap and mirror: negative time runs the pair backward
      frac = neg ? ((fm != 0) ? FracOne - fm : 64'd0) : fm;
      pos  = frac * (fc - 1);
      key  = pos >> aks_pkg::FracBits;
      if (neg) begin
        fr = key + 1;
        nx = key;
        bl = blend_from_frac(FracOne - (pos & FracMask), w.steps);
      end else begin
        fr = key;
        nx = key + 1;
        bl = blend_from_frac(pos & FracMask, w.steps);
      end
      // odd periods play mirrored
      if (w.mode == aks_pkg::ModeMirror && ip[0]) begin
        fr = fc - fr - 1;
        nx = fc - nx - 1;
      end
    end
    r.frame   = fr[15:0] & FcMask[15:0];
    r.next    = nx[15:0] & FcMask[15:0];
    r.blend   = bl;
    r.updated = upd;
    return r;
  endfunction

  task automatic add_word(logic signed [31:0] t, logic [1:0] m, logic [7:0] s,
                          logic [15:0] f, logic [31:0] d, logic [31:0] rc);
    word_t w;
    w.timeline = t;
    w.mode     = m;
    w.steps    = s;
    w.fc       = f;
    w.dur      = d;
    w.rcp      = rc;
    pending_words.push_back(w);
  endtask

  task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, name, exp_v, act_v);
    end
  endtask

  // Driver: bursts of back-to-back words, then a gap. A word counts as taken
  // at the edge where start is high and busy is low; that is when its
  // prediction is queued.
  int    burst_left = 0;
  int    gap_left   = 0;
  word_t cur_word;

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_samples.push_back(sample_keyframes(cur_word));
      end
      if (start && busy) begin
        // hold the word until the block takes it
      end else if (gap_left > 0) begin
        start <= 1'b0;
        gap_left--;
      end else if (pending_words.size() > 0) begin
        cur_word            = pending_words.pop_front();
        timeline            <= cur_word.timeline;
        play_mode           <= cur_word.mode;
        quantize_steps      <= cur_word.steps;
        frame_count         <= cur_word.fc;
        duration            <= cur_word.dur;
        duration_reciprocal <= cur_word.rcp;
        start               <= 1'b1;
        if (burst_left <= 1) begin
          // next burst; about a third of gaps are zero so long runs occur
          burst_left = $urandom_range(1, 24);
          case ($urandom_range(0, 9))
            0, 1, 2: gap_left = 0;
            3:       gap_left = $urandom_range(10, 30);
            default: gap_left = $urandom_range(1, 6);
          endcase
        end else begin
          burst_left--;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: results cannot be held off, so every done strobe is checked.
  always @(posedge clk) begin
    sample_t e;
    if (!rst && done) begin
      if (expected_samples.size() == 0) begin
        errors++;
        $display(
          "%0t: unexpected result: expected none, got frame %0h next %0h blend %0h upd %0b",
          $realtime, frame_index, next_frame_index, blend, updated);
      end else begin
        e = expected_samples.pop_front();
        check_field("frame_index", e.frame, frame_index);
        check_field("next_frame_index", e.next, next_frame_index);
        check_field("blend", e.blend, blend);
        check_field("updated", {15'd0, e.updated}, {15'd0, updated});
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int          sel;
    int          d;
    int          t;
    logic [63:0] r64;
    logic [1:0]  m;
    logic [7:0]  s;
    logic [15:0] f;

    // directed: one second duration, rcp = 1.0 in Q8.24
    add_word(32'sd32768, aks_pkg::ModeClamp, 8'd0, 16'd0, 32'h0001_0000,
             32'h0100_0000);   // no frames
    add_word(32'sd32768, aks_pkg::ModeWrap, 8'd0, 16'd1, 32'h0001_0000,
             32'h0100_0000);   // one frame
    add_word(32'sd32768, aks_pkg::ModeUnused, 8'd7, 16'd9, 32'h0001_0000,
             32'h0100_0000);   // bad mode
    add_word(32'sd0, aks_pkg::ModeClamp, 8'd0, 16'd10, 32'h0001_0000,
             32'h0100_0000);   // t = 0
    add_word(-32'sd5, aks_pkg::ModeClamp, 8'd0, 16'd10, 32'h0001_0000,
             32'h0100_0000);   // t < 0
    add_word(32'sh0001_0000, aks_pkg::ModeClamp, 8'd0, 16'd10, 32'h0001_0000,
             32'h0100_0000);   // t = dur
    add_word(32'sd40000, aks_pkg::ModeClamp, 8'd0, 16'd10, 32'h0001_0000,
             32'h0100_0000);   // inside
    add_word(32'sd40000, aks_pkg::ModeClamp, 8'd0, 16'd10, 32'h0001_0000,
             32'h0200_0000);   // rcp too big
    add_word(32'sd40000, aks_pkg::ModeClamp, 8'd4, 16'd10, 32'h0001_0000,
             32'h0100_0000);   // quantized
    add_word(32'sh0002_8000, aks_pkg::ModeWrap, 8'd0, 16'd17, 32'h0001_0000,
             32'h0100_0000);
    add_word(-32'sh0002_8000, aks_pkg::ModeWrap, 8'd0, 16'd17, 32'h0001_0000,
             32'h0100_0000);
    // negative whole period: reversed blend of exactly one
    add_word(-32'sh0002_0000, aks_pkg::ModeWrap, 8'd0, 16'd17, 32'h0001_0000,
             32'h0100_0000);
    add_word(-32'sh0002_0000, aks_pkg::ModeWrap, 8'd3, 16'd17, 32'h0001_0000,
             32'h0100_0000);
    add_word(32'sh0001_4000, aks_pkg::ModeMirror, 8'd0, 16'd5, 32'h0001_0000,
             32'h0100_0000);   // odd
    add_word(32'sh0002_4000, aks_pkg::ModeMirror, 8'd0, 16'd5, 32'h0001_0000,
             32'h0100_0000);   // even
    add_word(-32'sh0001_4000, aks_pkg::ModeMirror, 8'd255, 16'd5, 32'h0001_0000,
             32'h0100_0000);
    add_word(32'sh7FFF_FFFF, aks_pkg::ModeWrap, 8'd1, 16'hFFFF, 32'hFFFF_FFFF,
             32'hFFFF_FFFF);
    add_word(32'sh8000_0000, aks_pkg::ModeMirror, 8'd255, 16'hFFFF, 32'hFFFF_FFFF,
             32'hFFFF_FFFF);
    add_word(32'sh8000_0000, aks_pkg::ModeClamp, 8'd255, 16'hFFFF, 32'd0, 32'd0);
    add_word(32'sh7FFF_FFFF, aks_pkg::ModeClamp, 8'd0, 16'hFFFF, 32'hFFFF_FFFF, 32'd1);
    add_word(32'sd1, aks_pkg::ModeClamp, 8'd0, 16'd2, 32'd0, 32'hFFFF_FFFF);   // dur 0
    add_word(32'sd12345, aks_pkg::ModeWrap, 8'd0, 16'd2, 32'd0, 32'd0);        // rcp 0
    add_word(-32'sd1, aks_pkg::ModeWrap, 8'd0, 16'd3, 32'h0001_0000, 32'h0100_0000);

    // random: mostly consistent duration/reciprocal pairs, some raw noise
    for (int i = 0; i < NumRandom; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 75) begin
        d   = $urandom_range(32'h0000_1000, 32'h0040_0000);
        r64 = FracOne / d;
        if (r64 > 64'hFFFF_FFFF) r64 = 64'hFFFF_FFFF;
        if ($urandom_range(0, 7) == 0) r64 = r64 + $urandom_range(0, 64) - 32;
        case ($urandom_range(0, 9))
          0:       t = d;
          1:       t = d - 1;
          2:       t = $urandom_range(0, 2) - 1;
          3:       t = -d * $urandom_range(1, 3);
          default: t = $urandom_range(0, 8 * d) - 4 * d;
        endcase
        m = 2'($urandom_range(0, 2));
        case ($urandom_range(0, 19))
          0:       f = 16'($urandom_range(0, 1));
          1, 2:    f = 16'($urandom);
          default: f = 16'($urandom_range(2, 64));
        endcase
        s = ($urandom_range(0, 1) != 0) ? 8'd0 : 8'($urandom_range(1, 255));
        add_word(t, m, s, f, d, r64[31:0]);
      end else begin
        add_word($urandom, 2'($urandom_range(0, 3)), 8'($urandom), 16'($urandom),
                 $urandom, $urandom);
      end
    end

    // single reset at the start
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // drain: all words taken and all results seen
    do begin
      @(posedge clk);
    end while (pending_words.size() != 0 || start || expected_samples.size() != 0);
    repeat (DrainWait) @(posedge clk);

    if (errors == 0 && expected_samples.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// File: animation_keyframe_sampler_top.f
design/aks_pkg.sv
design/aks_time_norm.sv
design/aks_frame_pos.sv
design/aks_blend_quant.sv
design/animation_keyframe_sampler_top.sv
dv/tb_animation_keyframe_sampler_top.sv
